[rtl/satf_pkg.sv]
// Shared types and constants for the SYN / SYN-ACK timing filter.
// Used by the top level and its port checker; no dependencies.
package satf_pkg;

  localparam int unsigned IN_W  = 160;  // packed header beat width
  localparam int unsigned OUT_W = 8;    // result beat width, byte padded
  localparam int unsigned RES_W = 3;    // used result bits

  localparam logic [15:0] ETH_IPV4     = 16'h0800;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  FLAG_SYN     = 8'h02;
  localparam logic [7:0]  FLAG_SYNACK  = 8'h12;
  localparam logic [31:0] WINDOW_RESET = 32'd150;

  // Header beat, last field in the low bits.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
    logic [7:0]  tcp_flags;
    logic [7:0]  ip_protocol;
    logic [15:0] ether_type;
  } hdr_t;

  // Connection key as seen from the local host.
  typedef struct packed {
    logic [31:0] rip;    // remote address
    logic [15:0] rport;  // remote port
    logic [15:0] lport;  // local port
  } key_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] stamp;
    key_t        key;
  } slot_t;

  typedef struct packed {
    logic table_full;
    logic registered;
    logic drop;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_SYN,
    OP_SYNACK
  } op_e;

endpackage

[rtl/syn_ack_timing_filter_top.sv]
// SYN / SYN-ACK timing filter, top level.
// Depends on satf_pkg; the table is an internal one-write, one-read memory.

// One header beat per packet goes in; one result beat comes out. Outgoing
// IPv4 TCP SYNs (flags exactly 0x02) are written into the lowest free entry
// of a TABLE_DEPTH-entry table, keyed by remote address, remote port and
// local port and stamped with now_ms. Incoming SYN-ACKs (flags exactly 0x12)
// walk the whole table: entries older than window_ms (wrapping 32-bit age)
// are freed, and any surviving entry with a matching key sets drop. Matches
// are kept. Everything else passes with an all-zero result.
// Timing: the table sits in a memory read one entry per cycle through a
// registered read port, and one age/key compare unit checks each entry as
// it comes out. A SYN-ACK therefore reads every entry before its result is
// set, a SYN stops at the first free entry or reads every entry when the
// table is full, and any other packet skips the walk. s_axis_tready_o is
// high only between packets; the result sits in an output register, so the
// next packet is taken while a result still waits downstream. After reset
// the block first clears the table valid bits, one entry per cycle, through
// every entry with s_axis_tready_o low. The window register may be written
// at any time the block is between packets and is always ready.
module syn_ack_timing_filter_top #(
  parameter int unsigned TABLE_DEPTH = 64  // 1 .. 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // header beat
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // ether_type[15:0], ip_protocol[23:16], tcp_flags[31:24], src_ip[63:32],
  // dst_ip[95:64], src_port[111:96], dst_port[127:112], now_ms[159:128]
  input  logic [satf_pkg::IN_W-1:0]  s_axis_tdata_i,
  // is_send[0]
  input  logic [0:0]                 s_axis_tuser_i,
  // result beat
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // drop[0], registered[1], table_full[2], zero[7:3]
  output logic [satf_pkg::OUT_W-1:0] m_axis_tdata_o,
  // window_ms register
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [31:0]                cfg_data_i
);
  import satf_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_CNT = (AW+1)'(TABLE_DEPTH);

  state_e      state_q, state_d;
  logic [AW:0] idx_q, idx_d;      // clear / read issue counter
  logic        p_vld_q, p_vld_d;  // read data valid next cycle
  logic [AW-1:0] p_idx_q, p_idx_d;
  logic        hit_q, hit_d;
  result_t     res_q, res_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_res_q;
  logic        out_load;
  logic [31:0] window_q;

  // captured packet
  op_e         op_q, op_d;
  key_t        key_q, key_d;
  logic [31:0] now_q;

  // table memory
  slot_t       slot_mem_q [TABLE_DEPTH];
  slot_t       rd_data_q;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  slot_t       mem_wdata;

  hdr_t        hdr;
  logic        accept;
  logic        is_tcp4;
  logic [31:0] age;
  logic        expired;
  logic        match;
  logic        hit_nxt;

  assign hdr    = hdr_t'(s_axis_tdata_i);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_W-RES_W){1'b0}}, out_res_q};

  // decode and key selection
  always_comb begin
    is_tcp4 = (hdr.ether_type == ETH_IPV4) && (hdr.ip_protocol == PROTO_TCP);
    op_d    = OP_PASS;
    key_d   = '{rip: hdr.src_ip, rport: hdr.src_port, lport: hdr.dst_port};
    if (is_tcp4 && hdr.tcp_flags == FLAG_SYN && s_axis_tuser_i[0]) begin
      op_d  = OP_SYN;
      key_d = '{rip: hdr.dst_ip, rport: hdr.dst_port, lport: hdr.src_port};
    end else if (is_tcp4 && hdr.tcp_flags == FLAG_SYNACK && !s_axis_tuser_i[0]) begin
      op_d  = OP_SYNACK;
    end
  end

  // shared compare unit: wrapping age and key match on the entry read out
  assign age     = now_q - rd_data_q.stamp;
  assign expired = rd_data_q.valid && (age > window_q);
  assign match   = rd_data_q.valid && !expired && (rd_data_q.key == key_q);
  assign hit_nxt = hit_q || match;

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    p_vld_d   = 1'b0;
    p_idx_d   = p_idx_q;
    hit_d     = hit_q;
    res_d     = res_q;
    rd_en     = 1'b0;
    rd_addr   = idx_q[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = p_idx_q;
    mem_wdata = rd_data_q;
    out_load  = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = '0;
        if (idx_q[AW-1:0] == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          idx_d = '0;
          hit_d = 1'b0;
          res_d = '0;
          if (op_d == OP_PASS) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (idx_q < DEPTH_CNT) begin
          rd_en   = 1'b1;
          p_vld_d = 1'b1;
          p_idx_d = idx_q[AW-1:0];
          idx_d   = idx_q + 1'b1;
        end
        if (p_vld_q) begin
          if (op_q == OP_SYN) begin
            if (!rd_data_q.valid) begin
              mem_we    = 1'b1;
              mem_wdata = '{valid: 1'b1, stamp: now_q, key: key_q};
              res_d     = '{table_full: 1'b0, registered: 1'b1, drop: 1'b0};
              p_vld_d   = 1'b0;
              state_d   = ST_DONE;
            end else if (p_idx_q == LAST_IDX) begin
              res_d   = '{table_full: 1'b1, registered: 1'b0, drop: 1'b0};
              state_d = ST_DONE;
            end
          end else begin
            if (expired) begin
              mem_we          = 1'b1;
              mem_wdata.valid = 1'b0;
            end
            hit_d = hit_nxt;
            if (p_idx_q == LAST_IDX) begin
              res_d   = '{table_full: 1'b0, registered: 1'b0, drop: hit_nxt};
              state_d = ST_DONE;
            end
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      p_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= WINDOW_RESET;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      p_vld_q     <= p_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        window_q <= cfg_data_i;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    p_idx_q <= p_idx_d;
    hit_q   <= hit_d;
    res_q   <= res_d;
    if (accept) begin
      op_q  <= op_d;
      key_q <= key_d;
      now_q <= hdr.now_ms;
    end
    if (out_load) begin
      out_res_q <= res_q;
    end
  end

  // table memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= slot_mem_q[rd_addr];
    end
  end

endmodule

[rtl/satf_checker.sv]
// Port-level checker for the SYN / SYN-ACK timing filter, bound to the top.
// Depends on satf_pkg and on the port names of syn_ack_timing_filter_top.
module satf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [satf_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import satf_pkg::*;

  logic [1:0] pend_q;  // packets taken, results not yet taken
  logic       in_beat;
  logic       out_beat;
  result_t    res;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;
  assign res      = result_t'(m_axis_tdata_o[RES_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_beat && !out_beat) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_beat && !in_beat) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 2'd0)
    else $error("result beat without a pending packet");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two packets in flight");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(res.registered && res.table_full) &&
                        !(res.drop && (res.registered || res.table_full)))
    else $error("inconsistent result flags");

endmodule

bind syn_ack_timing_filter_top satf_checker u_satf_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for syn_ack_timing_filter_top: header beats in, result beats out.
// Depends on rtl/satf_pkg.sv and rtl/syn_ack_timing_filter_top.sv only.
// A built-in copy of the SYN table predicts each result and checks it in order.
module testbench;
  import satf_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned POOL        = 8;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  // DUT-facing signals; the driven ones are known from time zero
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  hdr_t                 s_axis_tdata_i  = '0;
  logic [0:0]           s_axis_tuser_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata_o;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [31:0]          cfg_data_i      = '0;

  syn_ack_timing_filter_top #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // Shadow of the SYN table and the window register.
  logic        syn_live  [DEPTH] = '{default: 1'b0};
  key_t        syn_key   [DEPTH];
  logic [31:0] syn_stamp [DEPTH];
  logic [31:0] window_ms_q = WINDOW_RESET;

  result_t     verdicts_due [$];   // one expected result beat per accepted header
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned ready_stall_pct = 0;
  result_t     seen_q;
  result_t     want_q;

  // Predicts the result beat of one header and updates the shadow table.
  function automatic result_t filter_verdict(input logic outbound, input hdr_t h);
    result_t     v;
    key_t        k;
    logic [31:0] age;
    int          i;
    v = '0;
    if (h.ether_type == ETH_IPV4 && h.ip_protocol == PROTO_TCP) begin
      if (outbound && h.tcp_flags == FLAG_SYN) begin
        k.rip   = h.dst_ip;
        k.rport = h.dst_port;
        k.lport = h.src_port;
        v.table_full = 1'b1;
        // lowest free entry wins
        for (i = 0; i < DEPTH; i++) begin
          if (!syn_live[i]) begin
            syn_live[i]  = 1'b1;
            syn_key[i]   = k;
            syn_stamp[i] = h.now_ms;
            v.registered = 1'b1;
            v.table_full = 1'b0;
            break;
          end
        end
      end else if (!outbound && h.tcp_flags == FLAG_SYNACK) begin
        k.rip   = h.src_ip;
        k.rport = h.src_port;
        k.lport = h.dst_port;
        // sweep: free stale entries, then match the survivors; matches stay
        for (i = 0; i < DEPTH; i++) begin
          if (syn_live[i]) begin
            age = h.now_ms - syn_stamp[i];
            if (age > window_ms_q) syn_live[i] = 1'b0;
            else if (syn_key[i] == k) v.drop = 1'b1;
          end
        end
      end
    end
    return v;
  endfunction

  function automatic key_t fresh_key();
    key_t k;
    k.rip   = $urandom;
    k.rport = $urandom;
    k.lport = $urandom;
    return k;
  endfunction

  // Outgoing SYN toward the remote side of k.
  function automatic hdr_t syn_hdr(input key_t k, input logic [31:0] t);
    hdr_t h;
    h.ether_type  = ETH_IPV4;
    h.ip_protocol = PROTO_TCP;
    h.tcp_flags   = FLAG_SYN;
    h.src_ip      = $urandom;
    h.dst_ip      = k.rip;
    h.src_port    = k.lport;
    h.dst_port    = k.rport;
    h.now_ms      = t;
    return h;
  endfunction

  // Incoming SYN-ACK from the remote side of k.
  function automatic hdr_t synack_hdr(input key_t k, input logic [31:0] t);
    hdr_t h;
    h.ether_type  = ETH_IPV4;
    h.ip_protocol = PROTO_TCP;
    h.tcp_flags   = FLAG_SYNACK;
    h.src_ip      = k.rip;
    h.dst_ip      = $urandom;
    h.src_port    = k.rport;
    h.dst_port    = k.lport;
    h.now_ms      = t;
    return h;
  endfunction

  // Sends one header beat. tvalid stays high on return so a following
  // call can go back to back; settle() drops it.
  task automatic send_header(input logic outbound, input hdr_t h);
    int unsigned gap;
    gap = 0;
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) gap++;
      // now and then a long gap, so it can end in any phase of a table walk
      if ($urandom_range(15) == 0) gap += $urandom_range(DEPTH + 8, 1);
    end
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= h;
    s_axis_tuser_i  <= outbound;
    do @(posedge clk_i); while (!s_axis_tready_o);
    verdicts_due.push_back(filter_verdict(outbound, h));
  endtask

  // Stops the sender and waits until every expected result beat is in.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_window(input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    window_ms_q = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string field, input logic want, input logic got);
    fault_count++;
    $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
  endtask

  // Result side: random backpressure and in-order compare.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        seen_q = result_t'(m_axis_tdata_o[RES_W-1:0]);
        if (verdicts_due.size() == 0) begin
          fault_count++;
          $display("%0t: result beat with none expected, expected none, actual %b",
                   $time, seen_q);
        end else begin
          want_q = verdicts_due.pop_front();
          if (seen_q.drop !== want_q.drop)
            note_mismatch("drop", want_q.drop, seen_q.drop);
          if (seen_q.registered !== want_q.registered)
            note_mismatch("registered", want_q.registered, seen_q.registered);
          if (seen_q.table_full !== want_q.table_full)
            note_mismatch("table_full", want_q.table_full, seen_q.table_full);
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Window edges, wrapping age, partial keys, wrong direction, stray flags,
  // non-IPv4 and non-TCP headers, all-zero and all-one fields.
  task automatic test_directed();
    key_t ka, kmax, kzero, kb;
    hdr_t h;
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    ka    = fresh_key();
    kmax  = '1;
    kzero = '0;
    send_header(1'b1, syn_hdr(ka, 32'd1000));
    send_header(1'b0, synack_hdr(ka, 32'd1150));   // age equals window: kept, drop
    send_header(1'b0, synack_hdr(ka, 32'd1151));   // one past: freed
    send_header(1'b0, synack_hdr(ka, 32'd1151));
    send_header(1'b1, syn_hdr(kmax, 32'hFFFF_FFF0));
    send_header(1'b1, syn_hdr(kzero, 32'hFFFF_FFF8));
    send_header(1'b0, synack_hdr(kmax, 32'h0000_0010)); // age across the wrap
    kb = kmax;
    kb.lport ^= 16'h0001;
    send_header(1'b0, synack_hdr(kb, 32'h10));
    kb = kzero;
    kb.rip ^= 32'h8000_0000;
    send_header(1'b0, synack_hdr(kb, 32'h10));
    send_header(1'b0, syn_hdr(kzero, 32'h10));     // SYN from the wire
    send_header(1'b1, synack_hdr(kzero, 32'h10));  // SYN-ACK to the wire
    h = syn_hdr(ka, 32'h20);
    h.tcp_flags = 8'h42;                            // SYN with ECE
    send_header(1'b1, h);
    h = synack_hdr(kzero, 32'h20);
    h.tcp_flags = 8'h52;                            // SYN-ACK with ECE
    send_header(1'b0, h);
    h = syn_hdr(ka, 32'h20);
    h.tcp_flags = 8'h00;
    send_header(1'b1, h);
    h = synack_hdr(kzero, 32'h20);
    h.tcp_flags = 8'hFF;
    send_header(1'b0, h);
    h = syn_hdr(ka, 32'h20);
    h.ether_type = 16'h86DD;
    send_header(1'b1, h);
    h = syn_hdr(ka, 32'h20);
    h.ip_protocol = 8'd17;
    send_header(1'b1, h);
    h = synack_hdr(kzero, 32'h20);
    h.ether_type  = '1;
    h.ip_protocol = '1;
    send_header(1'b0, h);
    send_header(1'b0, synack_hdr(kzero, 32'h20));  // still live
    send_header(1'b1, syn_hdr(ka, 32'hFFFF_FFFF));
    settle();
  endtask

  // Zero window: only an age of zero survives the sweep.
  task automatic test_zero_window();
    key_t kb;
    kb = fresh_key();
    set_window(32'd0);
    send_header(1'b1, syn_hdr(kb, 32'd5000));
    send_header(1'b0, synack_hdr(kb, 32'd5000));
    send_header(1'b0, synack_hdr(kb, 32'd5001));
    send_header(1'b1, syn_hdr(kb, 32'd6000));
    send_header(1'b0, synack_hdr(kb, 32'd5999));   // age wraps to all ones
    settle();
  endtask

  // Fill every entry with the widest window, overflow it, then flush it.
  task automatic test_table_full();
    key_t        held [DEPTH + 2];
    logic [31:0] base;
    int          i;
    send_idle_pct   = 12;
    ready_stall_pct = 12;
    base = $urandom;
    set_window(32'hFFFF_FFFF);
    for (i = 0; i < DEPTH + 2; i++) begin
      held[i] = fresh_key();
      send_header(1'b1, syn_hdr(held[i], base + i));
    end
    send_header(1'b0, synack_hdr(held[7], base + 32'd100_000)); // match is kept
    send_header(1'b0, synack_hdr(held[7], base + 32'd200_000));
    send_header(1'b0, synack_hdr(fresh_key(), base + 32'd5));
    settle();
    set_window(32'd0);
    send_header(1'b0, synack_hdr(held[0], base + 32'd5000));  // frees all
    send_header(1'b1, syn_hdr(held[0], base + 32'd5001));
    settle();
  endtask

  // Mostly well-formed SYN / SYN-ACK traffic on a small key pool, with
  // near misses and raw noise; two window settings per call.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input logic [31:0] win_a, input logic [31:0] win_b);
    logic [31:0] wins [2];
    key_t        pool [POOL];
    key_t        k;
    logic [31:0] tick;
    logic [31:0] span;
    hdr_t        h;
    logic        outbound;
    int unsigned roll;
    int          w, n, j;
    wins[0] = win_a;
    wins[1] = win_b;
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    for (w = 0; w < 2; w++) begin
      settle();
      set_window(wins[w]);
      for (j = 0; j < POOL; j++) pool[j] = fresh_key();
      tick = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3000) : $urandom;
      // time steps scaled to the window so entries age out now and then
      span = (wins[w] > 20000) ? 32'd20000 : wins[w] / 3 + 1;
      for (n = 0; n < 128; n++) begin
        if ($urandom_range(49) == 0) tick += $urandom;
        else tick += $urandom_range(span);
        k    = pool[$urandom_range(POOL - 1)];
        roll = $urandom_range(99);
        if (roll < 80) begin
          outbound = (roll < 45);
          h = outbound ? syn_hdr(k, tick) : synack_hdr(k, tick);
        end else if (roll < 90) begin
          // near miss: one field off by one bit
          outbound = $urandom_range(1);
          h = outbound ? syn_hdr(k, tick) : synack_hdr(k, tick);
          case ($urandom_range(4))
            0:       outbound = ~outbound;
            1:       h.ether_type  ^= 16'h1 << $urandom_range(15);
            2:       h.ip_protocol ^= 8'h1 << $urandom_range(7);
            3:       h.tcp_flags   ^= 8'h1 << $urandom_range(7);
            default: h.src_port    ^= 16'h1 << $urandom_range(15);
          endcase
        end else begin
          outbound = $urandom_range(1);
          h = hdr_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
          if ($urandom_range(1)) begin
            h.ether_type  = ETH_IPV4;
            h.ip_protocol = PROTO_TCP;
            if ($urandom_range(2) == 0) h.tcp_flags = $urandom_range(1) ? FLAG_SYN : FLAG_SYNACK;
          end
        end
        send_header(outbound, h);
        // sender holds off until the pipe is empty
        if ($urandom_range(63) == 0) settle();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_zero_window();
    test_table_full();
    test_random_traffic(0, 0, WINDOW_RESET, 32'hFFFF_FFFF);
    test_random_traffic(62, 0, 32'd0, $urandom_range(1000, 1));
    test_random_traffic(0, 62, 32'd1, $urandom);
    test_random_traffic(12, 12, 32'd40, 32'h7FFF_FFFF);
    settle();
    // catch any stray beat after the last expected one
    repeat (DEPTH + 8) @(posedge clk_i);
    if (fault_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
